// ===== rtl/tss_pkg.sv =====
// Shared types, constants and segment tables for the temperature display sequencer.
`default_nettype none

package tss_pkg;

    // Field widths
    localparam int SAMPLE_W        = 12;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int SEG_W           = 7;
    localparam int DIGIT_W         = 4;
    localparam int HUND_W          = 3;
    localparam int Q_W             = 16;   // scaled magnitude, below 59400

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_UNIT_SELECT = 1'b0;   // word index of unit_select

    localparam logic UNIT_F = 1'b0;
    localparam logic UNIT_C = 1'b1;

    // Conversion constants: temperature = (K * s - OFF * 2^N) / (D * 2^N)
    localparam logic [Q_W-1:0] K_C   = 16'd6600;
    localparam logic [Q_W-1:0] K_F   = 16'd59400;
    localparam logic [Q_W-1:0] OFF_C = 16'd800;
    localparam logic [Q_W-1:0] OFF_F = 16'd960;

    // Reciprocals, 16 fraction bits
    localparam int RECIP39 = 1680;
    localparam int RECIP5  = 13107;
    localparam int RECIP10 = 6554;
    localparam int RECIP10_SMALL = 205;   // 11 fraction bits, valid below 80

    // Segment codes
    localparam logic [SEG_W-1:0] SEG_BLANK    = 7'h00;
    localparam logic [SEG_W-1:0] SEG_MINUS    = 7'h40;
    localparam logic [SEG_W-1:0] SEG_LETTER_F = 7'h71;
    localparam logic [SEG_W-1:0] SEG_LETTER_C = 7'h39;

    typedef struct packed {
        logic               neg;
        logic               hund_en;
        logic [HUND_W-1:0]  hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
        logic               unit;
    } tss_temp_t;

    function automatic logic [SEG_W-1:0] digit_seg(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] seg;
        unique case (d)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tss_if.sv =====
// Valid/ready channel interfaces for samples and display codes.
`default_nettype none

interface tss_sample_if;
    logic                         valid;
    logic                         ready;
    logic [tss_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tss_code_if;
    logic                      valid;
    logic                      ready;
    logic [tss_pkg::SEG_W-1:0] segments;
    logic                      long_hold;
    logic                      last;

    modport source (output valid, output segments, output long_hold, output last, input ready);
    modport sink   (input valid, input segments, input long_hold, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/tss_regs.sv =====
// APB-style register block holding the unit select.
`default_nettype none

module tss_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tss_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tss_pkg::PDATA_W-1:0] pwdata,
    output logic      [tss_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output logic                             unit_select
);
    import tss_pkg::*;

    logic unit_reg;
    logic wr_unit;

    // word index is paddr[2]; byte lanes ignored
    assign wr_unit     = psel && penable && pwrite && (paddr[2] == REG_UNIT_SELECT);
    assign pready      = 1'b1;
    assign unit_select = unit_reg;
    assign prdata      = (paddr[2] == REG_UNIT_SELECT) ? {{(PDATA_W-1){1'b0}}, unit_reg}
                                                       : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= UNIT_F;
        end
        else if (wr_unit)
        begin
            unit_reg <= pwdata[0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tss_convert.sv =====
// Pipelined sample-to-digits conversion: scale, offset, divide, split into digits.
`default_nettype none

module tss_convert #(
    parameter int SAMPLE_BITS = tss_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          unit_select,
    tss_sample_if.sink         sample_ch,
    output logic               temp_valid,
    input  wire logic          temp_ready,
    output tss_pkg::tss_temp_t temp
);
    import tss_pkg::*;

    localparam int SW   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int DW   = SAMPLE_BITS + Q_W;
    localparam int NSTG = 9;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    // stage payloads
    logic [SW-1:0]  s0_reg;
    logic           u0_reg;
    logic [DW-1:0]  prod1_reg;
    logic           u1_reg;
    logic [Q_W-1:0] q2_reg;
    logic           n2_reg, u2_reg;
    logic [26:0]    p39_3_reg;
    logic [Q_W-1:0] q3_reg;
    logic           n3_reg, u3_reg;
    logic [10:0]    c39_4_reg;
    logic           n4_reg, u4_reg;
    logic [24:0]    p5_5_reg;
    logic [10:0]    c39_5_reg;
    logic           n5_reg, u5_reg;
    logic [9:0]     mag6_reg;
    logic           n6_reg, u6_reg;
    logic [22:0]    p10_7_reg;
    logic [9:0]     mag7_reg;
    logic           n7_reg, u7_reg;
    tss_temp_t      temp_reg;

    // combinational stage logic
    logic [DW-1:0]  prod_next;
    logic [DW-1:0]  off;
    logic [DW-1:0]  diff;
    logic           neg_next;
    logic [Q_W-1:0] q_next;
    logic [10:0]    est39;
    logic [16:0]    r39;
    logic [10:0]    c39_next;
    logic [8:0]     est5;
    logic [10:0]    r5;
    logic [8:0]     c5;
    logic [9:0]     mag_next;
    logic [6:0]     t1;
    logic [9:0]     ones_w;
    logic [13:0]    ph;
    logic [HUND_W-1:0] hund;
    logic [6:0]     tens_w;
    tss_temp_t      temp_next;

    // a stage loads when empty or when its content moves on
    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || temp_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign sample_ch.ready = en[0];
    assign temp_valid      = v_reg[NSTG-1];
    assign temp            = temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= sample_ch.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        // stage 1: scale
        prod_next = DW'(s0_reg) * DW'((u0_reg == UNIT_C) ? K_C : K_F);

        // stage 2: offset, sign and drop the 2^N denominator
        off = DW'((u1_reg == UNIT_C) ? OFF_C : OFF_F) << SAMPLE_BITS;
        neg_next = prod1_reg < off;
        diff = neg_next ? (off - prod1_reg) : (prod1_reg - off);
        q_next = Q_W'(diff >> SAMPLE_BITS);

        // stage 4: divide by 39 with one correction step
        est39 = p39_3_reg[26:16];
        r39 = 17'(q3_reg) - 17'(est39) * 17'd39;
        c39_next = (r39 >= 17'd39) ? 11'(est39 + 11'd1) : est39;

        // stage 6: divide by 5 for Fahrenheit
        est5 = p5_5_reg[24:16];
        r5 = c39_5_reg - 11'(est5) * 11'd5;
        c5 = (r5 >= 11'd5) ? 9'(est5 + 9'd1) : est5;
        mag_next = (u5_reg == UNIT_C) ? c39_5_reg[9:0] : 10'(c5);

        // stage 8: decimal digits
        t1 = p10_7_reg[22:16];
        ones_w = mag7_reg - 10'(t1) * 10'd10;
        ph = 14'(t1) * 14'(RECIP10_SMALL);
        hund = ph[13:11];
        tens_w = t1 - 7'(hund) * 7'd10;

        temp_next.neg     = n7_reg;
        temp_next.hund_en = t1 >= 7'd10;
        temp_next.hund    = hund;
        temp_next.tens    = tens_w[DIGIT_W-1:0];
        temp_next.ones    = ones_w[DIGIT_W-1:0];
        temp_next.unit    = u7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_reg <= sample_ch.sample[SW-1:0];
            u0_reg <= unit_select;
        end
        if (en[1])
        begin
            prod1_reg <= prod_next;
            u1_reg    <= u0_reg;
        end
        if (en[2])
        begin
            q2_reg <= q_next;
            n2_reg <= neg_next;
            u2_reg <= u1_reg;
        end
        if (en[3])
        begin
            p39_3_reg <= 27'(q2_reg) * 27'(RECIP39);
            q3_reg    <= q2_reg;
            n3_reg    <= n2_reg;
            u3_reg    <= u2_reg;
        end
        if (en[4])
        begin
            c39_4_reg <= c39_next;
            n4_reg    <= n3_reg;
            u4_reg    <= u3_reg;
        end
        if (en[5])
        begin
            p5_5_reg  <= 25'(c39_4_reg) * 25'(RECIP5);
            c39_5_reg <= c39_4_reg;
            n5_reg    <= n4_reg;
            u5_reg    <= u4_reg;
        end
        if (en[6])
        begin
            mag6_reg <= mag_next;
            n6_reg   <= n5_reg;
            u6_reg   <= u5_reg;
        end
        if (en[7])
        begin
            p10_7_reg <= 23'(mag6_reg) * 23'(RECIP10);
            mag7_reg  <= mag6_reg;
            n7_reg    <= n6_reg;
            u7_reg    <= u6_reg;
        end
        if (en[8])
        begin
            temp_reg <= temp_next;
        end
    end

    // digits out of the last stage must be decimal
    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NSTG-1] |-> (temp_reg.tens < 4'd10) && (temp_reg.ones < 4'd10))
        else $error("tss_convert: non-decimal digit");

endmodule

`default_nettype wire

// ===== rtl/tss_sequencer.sv =====
// Steps through the display run of one temperature and registers each code.
`default_nettype none

module tss_sequencer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             temp_valid,
    output logic                  temp_ready,
    input  wire tss_pkg::tss_temp_t temp,
    tss_code_if.source            code_ch
);
    import tss_pkg::*;

    typedef enum logic [3:0] {
        SL_MINUS,
        SL_MINUS_GAP,
        SL_HUND,
        SL_TENS,
        SL_TENS_GAP,
        SL_ONES,
        SL_ONES_GAP,
        SL_UNIT,
        SL_END
    } slot_t;

    slot_t            state_reg, state_next;
    slot_t            start_slot;
    tss_temp_t        cur_reg;
    logic             cur_valid_reg;
    logic             out_valid_reg;
    logic [SEG_W-1:0] seg_reg;
    logic             hold_reg;
    logic             last_reg;

    logic             load_out, emit, finish, take;
    logic [SEG_W-1:0] seg_next;
    logic             hold_next;
    logic             last_next;

    assign load_out   = !out_valid_reg || code_ch.ready;
    assign emit       = cur_valid_reg && load_out;
    assign finish     = emit && (state_reg == SL_END);
    assign temp_ready = !cur_valid_reg || finish;
    assign take       = temp_valid && temp_ready;

    assign code_ch.valid     = out_valid_reg;
    assign code_ch.segments  = seg_reg;
    assign code_ch.long_hold = hold_reg;
    assign code_ch.last      = last_reg;

    always_comb
    begin
        if (temp.neg)
        begin
            start_slot = SL_MINUS;
        end
        else if (temp.hund_en)
        begin
            start_slot = SL_HUND;
        end
        else
        begin
            start_slot = SL_TENS;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        seg_next   = SEG_BLANK;
        hold_next  = 1'b0;
        last_next  = 1'b0;
        unique case (state_reg)
            SL_MINUS:
            begin
                seg_next   = SEG_MINUS;
                hold_next  = 1'b1;
                state_next = SL_MINUS_GAP;
            end
            SL_MINUS_GAP:
            begin
                state_next = cur_reg.hund_en ? SL_HUND : SL_TENS;
            end
            SL_HUND:
            begin
                seg_next   = digit_seg(DIGIT_W'(cur_reg.hund));
                hold_next  = 1'b1;
                state_next = SL_TENS;
            end
            SL_TENS:
            begin
                seg_next   = digit_seg(cur_reg.tens);
                hold_next  = 1'b1;
                state_next = SL_TENS_GAP;
            end
            SL_TENS_GAP:
            begin
                state_next = SL_ONES;
            end
            SL_ONES:
            begin
                seg_next   = digit_seg(cur_reg.ones);
                hold_next  = 1'b1;
                state_next = SL_ONES_GAP;
            end
            SL_ONES_GAP:
            begin
                state_next = SL_UNIT;
            end
            SL_UNIT:
            begin
                seg_next   = (cur_reg.unit == UNIT_C) ? SEG_LETTER_C : SEG_LETTER_F;
                hold_next  = 1'b1;
                state_next = SL_END;
            end
            SL_END:
            begin
                last_next = 1'b1;
            end
            default:
            begin
                state_next = SL_END;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SL_END;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            seg_reg       <= SEG_BLANK;
            hold_reg      <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                seg_reg       <= seg_next;
                hold_reg      <= hold_next;
                last_reg      <= last_next;
            end
            else if (code_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (take)
            begin
                state_reg     <= start_slot;
                cur_valid_reg <= 1'b1;
            end
            else
            begin
                if (emit)
                begin
                    state_reg <= state_next;
                end
                if (finish)
                begin
                    cur_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= temp;
        end
    end

    a_short_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hold_reg |-> seg_reg == SEG_BLANK)
        else $error("tss_sequencer: short pause with lit segments");

    a_last_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> !hold_reg && (seg_reg == SEG_BLANK))
        else $error("tss_sequencer: run does not end in a blank");

    a_hund_only_when_due: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && (state_reg == SL_HUND) |-> cur_reg.hund_en)
        else $error("tss_sequencer: hundreds slot for a two-digit value");

    a_minus_only_when_neg: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && (state_reg == SL_MINUS || state_reg == SL_MINUS_GAP)
        |-> cur_reg.neg)
        else $error("tss_sequencer: minus sign for a non-negative value");

endmodule

`default_nettype wire

// ===== rtl/temperature_seven_segment_sequencer_top.sv =====
// Top level of the temperature seven-segment display sequencer.
//
// Usage:
//   sample_ch (sink) takes one sensor sample per transaction. The low
//   SAMPLE_BITS bits stand for a voltage of sample * 3.3 / 2^SAMPLE_BITS.
//   code_ch (source) gives one seven-segment code per transaction with a
//   hold flag (long_hold) and a marker on the run's final code (last).
//   Each sample yields a run of 6 to 9 codes: optional minus and blank,
//   optional hundreds digit, tens, blank, ones, blank, unit letter, blank.
//   The APB port holds unit_select at byte address 0 (0 = Fahrenheit,
//   1 = Celsius); write it only while no sample is in flight.
// Path: a sample passes through the nine conversion stages, the sequencer's
//   digit register and the code register before the first code of its run
//   is valid.
// Throughput: the code sequencer gives one code per cycle while code_ch.ready
//   stays high, so one sample per run of codes. The pipeline keeps taking
//   samples while a run is being sent, up to its depth.
// Reset: rst_n clears unit_select to Fahrenheit and empties the pipeline.
// Stall: with code_ch.ready low the current code holds; the pipeline stages
//   fill up, then sample_ch.ready drops. Nothing is lost or repeated.
`default_nettype none

module temperature_seven_segment_sequencer_top #(
    parameter int SAMPLE_BITS = tss_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    tss_sample_if.sink                       sample_ch,
    tss_code_if.source                       code_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tss_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tss_pkg::PDATA_W-1:0] pwdata,
    output logic      [tss_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);
    import tss_pkg::*;

    logic      unit_select;
    logic      temp_valid;
    logic      temp_ready;
    tss_temp_t temp;

    // configuration register
    tss_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .unit_select (unit_select)
    );

    // sample -> sign and decimal digits, one sample per cycle unless temp_ready holds the pipeline
    tss_convert #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_convert (
        .clk         (clk),
        .rst_n       (rst_n),
        .unit_select (unit_select),
        .sample_ch   (sample_ch),
        .temp_valid  (temp_valid),
        .temp_ready  (temp_ready),
        .temp        (temp)
    );

    // digits -> run of display codes
    tss_sequencer u_sequencer (
        .clk        (clk),
        .rst_n      (rst_n),
        .temp_valid (temp_valid),
        .temp_ready (temp_ready),
        .temp       (temp),
        .code_ch    (code_ch)
    );

endmodule

`default_nettype wire
